### hw/rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and constants of the modulator PWM dither block.
// Holds the input kind codes, register indexes, widths and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

	// Field widths.
	localparam int KIND_W = 2;
	localparam int LVL_W  = 8;
	localparam int DUTY_W = 10;
	localparam int IDX_W  = 3;

	// Width of the amplitude arithmetic, which wraps at this many bits.
	localparam int ACC_W   = 16;
	localparam int DCNT_W  = $clog2(ACC_W);

	// Input kind codes.
	localparam logic [KIND_W-1:0] KIND_SHAPED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RAW    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_MIN_MOD    = 3'd0;
	localparam logic [IDX_W-1:0] REG_FULL_MOD   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CEILING    = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_OSC    = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN_OSC    = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOW_LIMIT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_HIGH_LIMIT = 3'd6;
	localparam logic [IDX_W-1:0] REG_OSC_ENABLE = 3'd7;

	// Arithmetic constants.
	localparam logic [ACC_W-1:0] PERCENT   = 16'd100;
	localparam logic [LVL_W-1:0] LEVEL_MAX = 8'hFF;

	// Division by one hundred as a multiply by ceil(2^23 / 100) and a shift.
	// The rounding error stays below one for every 16-bit dividend.
	localparam int                 RECIP_W   = 17;
	localparam int                 RECIP_SH  = 23;
	localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_lvl;    // latch the clamped level for the amplitude run
		logic wr_raw;    // store the raw level with zero amplitude
		logic wr_plain;  // store the clamped level with zero amplitude
		logic mul_num;   // numerator: (level - min_mod) * 100
		logic div_start; // start the divider: numerator / span
		logic mul_span;  // quotient * (max_osc - min_osc)
		logic mul_recip; // product / 100 by the reciprocal multiply
		logic finish;    // limit the amplitude and store the pair
		logic tick;      // advance the dither and load the output word
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic osc_en;
		logic div_done;
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/mpd_div.sv
// ----------------------------------------------------------------------------
// mpd_div: iterative unsigned divider.
// Restoring division, one quotient bit per cycle. A zero divisor gives a
// quotient of all ones. The quotient holds after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [mpd_pkg::ACC_W-1:0] dividend,
	input  wire logic [mpd_pkg::ACC_W-1:0] divisor,
	output logic      [mpd_pkg::ACC_W-1:0] quotient,
	output logic                           done
);
	import mpd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]  rem_q;
	logic [ACC_W-1:0]  quo_q;
	logic [ACC_W-1:0]  dvs_q;

	logic [ACC_W:0]    shifted;
	logic [ACC_W:0]    trial;
	logic              fits;

	// One restoring step.
	always_comb begin
		shifted = {rem_q, quo_q[ACC_W-1]};
		trial   = shifted - {1'b0, dvs_q};
		fits    = (shifted >= {1'b0, dvs_q});
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[ACC_W-1:0] : shifted[ACC_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

### hw/rtl/mpd_dpath.sv
// ----------------------------------------------------------------------------
// mpd_dpath: datapath of the modulator PWM dither block.
// Configuration registers, level clamp, amplitude arithmetic around the
// divider, the held and live level pairs and the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_dpath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [mpd_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [mpd_pkg::LVL_W-1:0]  cfg_data,
	input  wire logic [mpd_pkg::LVL_W-1:0]  level,
	input  wire mpd_pkg::cmd_t              cmd,
	output mpd_pkg::sts_t                   sts,
	output logic      [mpd_pkg::DUTY_W-1:0] duty_word
);
	import mpd_pkg::*;

	// Configuration registers.
	logic [LVL_W-1:0] min_mod_q, full_mod_q, ceiling_q, max_osc_q, min_osc_q;
	logic [LVL_W-1:0] low_limit_q, high_limit_q;
	logic             osc_enable_q;

	// Block state.
	logic [LVL_W-1:0] held_level_q, held_amp_q, live_level_q, live_amp_q;
	logic             reload_q, phase_q;

	// Work registers of the amplitude run and the output word.
	logic [LVL_W-1:0]  lvl_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DUTY_W-1:0] duty_q;

	logic [LVL_W-1:0]    lo_clamp, clamped;
	logic [ACC_W-1:0]    lvl_diff, span, osc_span;
	logic [ACC_W+6:0]    num_prod;
	logic [2*ACC_W-1:0]  span_prod;
	logic [ACC_W+RECIP_W-1:0] recip_prod;
	logic [ACC_W-1:0]    div_dvd, div_dvs, quo;
	logic                div_done;
	logic [LVL_W-1:0]    amp_base, amp_fin;
	logic signed [LVL_W+1:0] up_s, down_s, amp_s;
	logic [LVL_W-1:0]    src_lvl, src_amp, sat_lvl;
	logic [LVL_W:0]      moved;

	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mod_q    <= '0;
			full_mod_q   <= LEVEL_MAX;
			ceiling_q    <= LEVEL_MAX;
			max_osc_q    <= '0;
			min_osc_q    <= '0;
			low_limit_q  <= '0;
			high_limit_q <= LEVEL_MAX;
			osc_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_MOD:    min_mod_q    <= cfg_data;
				REG_FULL_MOD:   full_mod_q   <= cfg_data;
				REG_CEILING:    ceiling_q    <= cfg_data;
				REG_MAX_OSC:    max_osc_q    <= cfg_data;
				REG_MIN_OSC:    min_osc_q    <= cfg_data;
				REG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				REG_OSC_ENABLE: osc_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp of a shaped write; the ceiling is applied last and wins.
	always_comb begin
		lo_clamp = (level < min_mod_q) ? min_mod_q : level;
		clamped  = (lo_clamp > ceiling_q) ? ceiling_q : lo_clamp;
	end

	// Differences and products, all wrapping at the accumulator width.
	always_comb begin
		lvl_diff   = {8'h00, lvl_q} - {8'h00, min_mod_q};
		span       = {8'h00, full_mod_q} - {8'h00, min_mod_q};
		osc_span   = {8'h00, max_osc_q} - {8'h00, min_osc_q};
		num_prod   = lvl_diff * PERCENT[6:0];
		span_prod  = quo * osc_span;
		recip_prod = acc_q * RECIP_100;
		div_dvd    = acc_q;
		div_dvs    = span;
	end

	mpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (quo),
		.done     (div_done)
	);

	// Amplitude from the scaled step, then limited by the distances to
	// the high and low limits as signed values.
	always_comb begin
		if (lvl_q >= full_mod_q || acc_q > {8'h00, max_osc_q}) begin
			amp_base = min_osc_q;
		end else begin
			amp_base = max_osc_q - acc_q[LVL_W-1:0];
		end
		up_s   = $signed({2'b00, high_limit_q}) - $signed({2'b00, lvl_q});
		down_s = $signed({2'b00, lvl_q}) - $signed({2'b00, low_limit_q});
		amp_s  = $signed({2'b00, amp_base});
		if (amp_s > up_s) begin
			amp_fin = up_s[LVL_W-1:0];
		end else if (amp_s > down_s) begin
			amp_fin = down_s[LVL_W-1:0];
		end else begin
			amp_fin = amp_base;
		end
	end

	// Tick: reload, offset by the amplitude and saturate; a borrow or a
	// carry out of the level both read as full scale.
	always_comb begin
		src_lvl = reload_q ? held_level_q : live_level_q;
		src_amp = reload_q ? held_amp_q : live_amp_q;
		if (!osc_enable_q) begin
			moved = {1'b0, src_lvl};
		end else if (!phase_q) begin
			moved = {1'b0, src_lvl} - {1'b0, src_amp};
		end else begin
			moved = {1'b0, src_lvl} + {1'b0, src_amp};
		end
		sat_lvl = moved[LVL_W] ? LEVEL_MAX : moved[LVL_W-1:0];
	end

	// Held pair, live pair and dither phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_level_q <= '0;
			held_amp_q   <= '0;
			reload_q     <= 1'b0;
			live_level_q <= '0;
			live_amp_q   <= '0;
			phase_q      <= 1'b0;
		end else begin
			if (cmd.wr_raw) begin
				held_level_q <= level;
				held_amp_q   <= '0;
				reload_q     <= 1'b1;
			end else if (cmd.wr_plain) begin
				held_level_q <= clamped;
				held_amp_q   <= '0;
				reload_q     <= 1'b1;
			end else if (cmd.finish) begin
				held_level_q <= lvl_q;
				held_amp_q   <= amp_fin;
				reload_q     <= 1'b1;
			end
			if (cmd.tick) begin
				live_level_q <= sat_lvl;
				live_amp_q   <= src_amp;
				if (osc_enable_q) begin
					phase_q <= ~phase_q;
				end
			end
		end
	end

	// Work registers and output word.
	always_ff @(posedge clk) begin
		if (cmd.ld_lvl) begin
			lvl_q <= clamped;
		end
		if (cmd.mul_num) begin
			acc_q <= num_prod[ACC_W-1:0];
		end else if (cmd.mul_span) begin
			acc_q <= span_prod[ACC_W-1:0];
		end else if (cmd.mul_recip) begin
			acc_q <= ACC_W'(recip_prod >> RECIP_SH);
		end
		if (cmd.tick) begin
			duty_q <= {1'b0, sat_lvl, 1'b0};
		end
	end

	assign sts.osc_en   = osc_enable_q;
	assign sts.div_done = div_done;
	assign duty_word    = duty_q;

endmodule

`default_nettype wire

### hw/rtl/mpd_ctrl.sv
// ----------------------------------------------------------------------------
// mpd_ctrl: controller of the modulator PWM dither block.
// Decodes accepted words, sequences the amplitude run through the divider
// and the reciprocal multiply, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [mpd_pkg::KIND_W-1:0] kind,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output mpd_pkg::cmd_t                   cmd,
	input  wire mpd_pkg::sts_t              sts
);
	import mpd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_NUM   = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_WAIT  = 4'd3;
	localparam logic [3:0] ST_SPAN  = 4'd4;
	localparam logic [3:0] ST_SCALE = 4'd5;
	localparam logic [3:0] ST_FIN   = 4'd6;
	localparam logic [3:0] ST_TICK  = 4'd7;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept, out_free;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		accept   = in_valid && in_ready;
		out_free = !out_valid_q || out_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_SHAPED: begin
							if (sts.osc_en) begin
								cmd.ld_lvl = 1'b1;
								state_d    = ST_NUM;
							end else begin
								cmd.wr_plain = 1'b1;
							end
						end
						KIND_RAW: cmd.wr_raw = 1'b1;
						KIND_TICK: begin
							if (out_free) begin
								cmd.tick = 1'b1;
							end else begin
								state_d = ST_TICK;
							end
						end
						default: ;
					endcase
				end
			end
			ST_NUM: begin
				cmd.mul_num = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: begin
				cmd.mul_span = 1'b1;
				state_d      = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.mul_recip = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_TICK: begin
				if (out_free) begin
					cmd.tick = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.tick) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A new duty word never overwrites one that was not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |-> (!out_valid_q || out_ready))
		else $error("duty word overwritten before it was taken");

	// The divider only finishes while the controller waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_WAIT))
		else $error("divider finished outside the wait state");

	// A divide never completes in the cycle after it starts.
	a_div_takes_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider finished too early");

	// At most one update of the held pair per cycle.
	a_one_hold_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_raw, cmd.wr_plain, cmd.finish}))
		else $error("conflicting writes of the held pair");

endmodule

`default_nettype wire

### hw/rtl/modulator_pwm_dither.sv
// ----------------------------------------------------------------------------
// modulator_pwm_dither: gas-valve modulator PWM with dither.
// Raw writes and shaped writes without oscillation complete in the idle
// state, as does a tick while the output register is free. A shaped write
// with oscillation enabled runs the amplitude computation through a 16-bit
// divider that yields one quotient bit per cycle and then divides by one
// hundred with a reciprocal multiply; no further input word is taken until
// that run is done. A duty word waits in an output register while writes
// are taken; a tick that arrives while that register is still full waits
// for it to drain. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module modulator_pwm_dither (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [mpd_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [mpd_pkg::LVL_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [mpd_pkg::KIND_W-1:0] kind,
	input  wire logic [mpd_pkg::LVL_W-1:0]  level,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [mpd_pkg::DUTY_W-1:0] duty_word
);
	import mpd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencing and handshakes.
	mpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Registers and arithmetic.
	mpd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.level     (level),
		.cmd       (cmd),
		.sts       (sts),
		.duty_word (duty_word)
	);

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the modulator PWM dither block.
// A short table of directed words covers reset behavior, clamping, raw and
// shaped writes, the unused kind, underflow and a zero span. Random phases
// follow under several register settings and idling patterns, including one
// long output hold that backs the block up. Every duty word is checked
// against a typed value or a model of level, amplitude and dither state.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import mpd_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 6;
	localparam int DRAIN_CYCLES   = 64;
	localparam int HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PHASE_WORDS    = 55;
	localparam int NUM_PHASES     = 8;
	localparam int PRESSURE_PHASE = 4;
	localparam int NUM_DIRECTED   = 41;

	// Register programming styles for the random phases.
	localparam int CFG_ZERO   = 0;
	localparam int CFG_FULL   = 1;
	localparam int CFG_SHAPED = 2;
	localparam int CFG_FREE   = 3;
	localparam int CFG_PLAIN  = 4;

	typedef struct {
		bit                is_reg;
		logic [IDX_W-1:0]  reg_idx;
		logic [KIND_W-1:0] kind;
		logic [LVL_W-1:0]  value;
		bit                typed;
		logic [DUTY_W-1:0] duty;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [LVL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] in_kind = '0;
	logic [LVL_W-1:0] in_level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DUTY_W-1:0] duty_word;

	// Shadow registers and dither state of the local model.
	logic [LVL_W-1:0] cfg_shadow [8];
	logic [LVL_W-1:0] held_level = '0;
	logic [LVL_W-1:0] held_amp = '0;
	bit reload_ready = 1'b0;
	logic [15:0] live_level = '0;
	logic [LVL_W-1:0] live_amp = '0;
	bit dither_phase = 1'b0;

	logic [DUTY_W-1:0] duty_expected [$];
	stim_row_t directed_rows [NUM_DIRECTED];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pressure_on = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int fail_count = 0;
	int cycle_count = 0;

	modulator_pwm_dither uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (in_kind),
		.level     (in_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.duty_word (duty_word)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Amplitude for a clamped level: linear fall in percent steps with 16-bit
	// wrap, then limited by the signed distance to either dither limit.
	function automatic logic [LVL_W-1:0] dither_amp(input logic [LVL_W-1:0] lv);
		logic [15:0] acc;
		logic [15:0] span;
		logic [LVL_W-1:0] amp;
		int up;
		int down;
		if (lv >= cfg_shadow[REG_FULL_MOD]) begin
			amp = cfg_shadow[REG_MIN_OSC];
		end else begin
			acc = 16'(lv) - 16'(cfg_shadow[REG_MIN_MOD]);
			acc = acc * PERCENT;
			span = 16'(cfg_shadow[REG_FULL_MOD]) - 16'(cfg_shadow[REG_MIN_MOD]);
			acc = (span == 16'd0) ? 16'hFFFF : acc / span;
			acc = acc * (16'(cfg_shadow[REG_MAX_OSC]) - 16'(cfg_shadow[REG_MIN_OSC]));
			acc = acc / PERCENT;
			if (acc > 16'(cfg_shadow[REG_MAX_OSC]))
				amp = cfg_shadow[REG_MIN_OSC];
			else
				amp = cfg_shadow[REG_MAX_OSC] - acc[7:0];
		end
		up = int'(cfg_shadow[REG_HIGH_LIMIT]) - int'(lv);
		down = int'(lv) - int'(cfg_shadow[REG_LOW_LIMIT]);
		if (int'(amp) > up)
			amp = up[7:0];
		else if (int'(amp) > down)
			amp = down[7:0];
		return amp;
	endfunction

	// Advance the model by one accepted word; ticks yield a duty word.
	task automatic predict_word(input logic [KIND_W-1:0] k, input logic [LVL_W-1:0] lv,
			output bit produces, output logic [DUTY_W-1:0] duty);
		logic [LVL_W-1:0] clamped;
		produces = 1'b0;
		duty = '0;
		case (k)
			KIND_SHAPED: begin
				clamped = lv;
				if (clamped < cfg_shadow[REG_MIN_MOD])
					clamped = cfg_shadow[REG_MIN_MOD];
				if (clamped > cfg_shadow[REG_CEILING])
					clamped = cfg_shadow[REG_CEILING];
				held_level = clamped;
				held_amp = cfg_shadow[REG_OSC_ENABLE][0] ? dither_amp(clamped) : '0;
				reload_ready = 1'b1;
			end
			KIND_RAW: begin
				held_level = lv;
				held_amp = '0;
				reload_ready = 1'b1;
			end
			KIND_TICK: begin
				if (reload_ready) begin
					live_level = 16'(held_level);
					live_amp = held_amp;
				end
				if (cfg_shadow[REG_OSC_ENABLE][0]) begin
					if (!dither_phase)
						live_level = live_level - 16'(live_amp);
					else
						live_level = live_level + 16'(live_amp);
					dither_phase = !dither_phase;
				end
				// Underflow wraps high and saturates like an overflow.
				if (live_level > 16'(LEVEL_MAX))
					live_level = 16'(LEVEL_MAX);
				duty = {live_level[8:0], 1'b0};
				produces = 1'b1;
			end
			default: begin
			end
		endcase
	endtask

	// Offer one input word, with random idle cycles ahead of it.
	task automatic send_word(input logic [KIND_W-1:0] k, input logic [LVL_W-1:0] lv,
			input bit typed, input logic [DUTY_W-1:0] typed_duty);
		bit produces;
		logic [DUTY_W-1:0] duty;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			in_kind <= KIND_W'($urandom);
			in_level <= LVL_W'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_kind <= k;
		in_level <= lv;
		do @(posedge clk); while (!in_ready);
		predict_word(k, lv, produces, duty);
		if (produces)
			duty_expected.push_back(typed ? typed_duty : duty);
	endtask

	// Write one register; the channel drops for a cycle after each word.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LVL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_shadow[idx] = (idx == REG_OSC_ENABLE) ? LVL_W'(data[0]) : data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering words, collect every pending duty word, then let a
	// possible amplitude run finish before anything is reprogrammed.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (duty_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input int style);
		logic [LVL_W-1:0] v [8];
		int lo;
		for (int i = 0; i < 8; i++)
			v[i] = (style == CFG_ZERO) ? 8'h00 : (style == CFG_FULL) ? 8'hFF : LVL_W'($urandom);
		if (style == CFG_ZERO)
			v[REG_OSC_ENABLE] = 8'h01;
		if (style == CFG_SHAPED || style == CFG_PLAIN) begin
			// Ordered settings that keep the amplitude arithmetic in range.
			lo = $urandom_range(100);
			v[REG_MIN_MOD] = LVL_W'(lo);
			v[REG_FULL_MOD] = LVL_W'($urandom_range(255, lo + 1));
			v[REG_CEILING] = LVL_W'($urandom_range(255, lo));
			v[REG_MAX_OSC] = LVL_W'($urandom_range(80));
			v[REG_MIN_OSC] = LVL_W'($urandom_range(int'(v[REG_MAX_OSC])));
			v[REG_LOW_LIMIT] = LVL_W'($urandom_range(lo));
			v[REG_HIGH_LIMIT] = LVL_W'($urandom_range(255, 150));
			v[REG_OSC_ENABLE][0] = (style == CFG_SHAPED);
		end
		write_reg(REG_MIN_MOD, v[REG_MIN_MOD]);
		write_reg(REG_FULL_MOD, v[REG_FULL_MOD]);
		write_reg(REG_CEILING, v[REG_CEILING]);
		write_reg(REG_MAX_OSC, v[REG_MAX_OSC]);
		write_reg(REG_MIN_OSC, v[REG_MIN_OSC]);
		write_reg(REG_LOW_LIMIT, v[REG_LOW_LIMIT]);
		write_reg(REG_HIGH_LIMIT, v[REG_HIGH_LIMIT]);
		write_reg(REG_OSC_ENABLE, v[REG_OSC_ENABLE]);
	endtask

	// Output side: random stalls, plus one long hold during the pressure phase.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (pressure_on && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each accepted duty word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (duty_expected.size() == 0) begin
				$error("duty_word: expected none, actual %0d", duty_word);
				fail_count++;
			end else begin
				if (duty_word !== duty_expected[0]) begin
					$error("duty_word: expected %0d, actual %0d", duty_expected[0], duty_word);
					fail_count++;
				end
				void'(duty_expected.pop_front());
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int style [NUM_PHASES];
		int done_words;
		int roll;
		logic [KIND_W-1:0] k;
		logic [LVL_W-1:0] lv;

		cfg_shadow[REG_MIN_MOD] = 8'd0;
		cfg_shadow[REG_FULL_MOD] = 8'd255;
		cfg_shadow[REG_CEILING] = 8'd255;
		cfg_shadow[REG_MAX_OSC] = 8'd0;
		cfg_shadow[REG_MIN_OSC] = 8'd0;
		cfg_shadow[REG_LOW_LIMIT] = 8'd0;
		cfg_shadow[REG_HIGH_LIMIT] = 8'd255;
		cfg_shadow[REG_OSC_ENABLE] = 8'd0;

		// Reset defaults first, then a well-ordered setting, then one where
		// the ceiling sits under min_mod, the span is zero and the dither
		// reaches under zero.
		directed_rows = '{
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'hA5, 1'b1, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_UNUSED, 8'hFF, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h00, 1'b1, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_RAW,    8'hFF, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h5A, 1'b1, 10'd510},
			'{1'b0, REG_MIN_MOD, KIND_SHAPED, 8'h00, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'hFF, 1'b1, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_RAW,    8'h80, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_UNUSED, 8'h11, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h3C, 1'b1, 10'd256},
			'{1'b1, REG_MIN_MOD,    KIND_SHAPED, 8'd20,  1'b0, 10'd0},
			'{1'b1, REG_FULL_MOD,   KIND_SHAPED, 8'd200, 1'b0, 10'd0},
			'{1'b1, REG_CEILING,    KIND_SHAPED, 8'd180, 1'b0, 10'd0},
			'{1'b1, REG_MAX_OSC,    KIND_SHAPED, 8'd40,  1'b0, 10'd0},
			'{1'b1, REG_MIN_OSC,    KIND_SHAPED, 8'd10,  1'b0, 10'd0},
			'{1'b1, REG_LOW_LIMIT,  KIND_SHAPED, 8'd5,   1'b0, 10'd0},
			'{1'b1, REG_HIGH_LIMIT, KIND_SHAPED, 8'd250, 1'b0, 10'd0},
			'{1'b1, REG_OSC_ENABLE, KIND_SHAPED, 8'd1,   1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_SHAPED, 8'h00, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h01, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'hFE, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_SHAPED, 8'hFF, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h00, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h77, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_SHAPED, 8'd110, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h88, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h33, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_RAW,    8'h03, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'hCC, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h44, 1'b0, 10'd0},
			'{1'b1, REG_MIN_MOD,    KIND_SHAPED, 8'd50,  1'b0, 10'd0},
			'{1'b1, REG_FULL_MOD,   KIND_SHAPED, 8'd50,  1'b0, 10'd0},
			'{1'b1, REG_CEILING,    KIND_SHAPED, 8'd30,  1'b0, 10'd0},
			'{1'b1, REG_MAX_OSC,    KIND_SHAPED, 8'd200, 1'b0, 10'd0},
			'{1'b1, REG_MIN_OSC,    KIND_SHAPED, 8'd5,   1'b0, 10'd0},
			'{1'b1, REG_LOW_LIMIT,  KIND_SHAPED, 8'd100, 1'b0, 10'd0},
			'{1'b1, REG_HIGH_LIMIT, KIND_SHAPED, 8'd255, 1'b0, 10'd0},
			'{1'b1, REG_OSC_ENABLE, KIND_SHAPED, 8'd1,   1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_SHAPED, 8'h00, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h99, 1'b0, 10'd0},
			'{1'b0, REG_MIN_MOD, KIND_TICK,   8'h66, 1'b0, 10'd0}
		};
		style = '{CFG_SHAPED, CFG_SHAPED, CFG_FREE, CFG_SHAPED,
			CFG_SHAPED, CFG_ZERO, CFG_FULL, CFG_PLAIN};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; registers change only once the block is idle.
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (directed_rows[i].is_reg) begin
				if (i > 0 && !directed_rows[i - 1].is_reg)
					drain_pipeline();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				send_word(directed_rows[i].kind, directed_rows[i].value,
					directed_rows[i].typed, directed_rows[i].duty);
			end
		end
		drain_pipeline();

		// Random phases, each with a register setting and one of four idling patterns.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			program_regs(style[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			pressure_on = (ph == PRESSURE_PHASE);
			done_words = 0;
			while (done_words < PHASE_WORDS) begin
				roll = $urandom_range(99);
				if (pressure_on)
					k = (roll < 90) ? KIND_TICK : KIND_SHAPED;
				else if (roll < 55)
					k = KIND_TICK;
				else if (roll < 80)
					k = KIND_SHAPED;
				else if (roll < 93)
					k = KIND_RAW;
				else
					k = KIND_UNUSED;
				case ($urandom_range(7))
					0: lv = 8'h00;
					1: lv = 8'hFF;
					default: lv = LVL_W'($urandom);
				endcase
				send_word(k, lv, 1'b0, '0);
				if (k != KIND_UNUSED)
					done_words++;
			end
			drain_pipeline();
			pressure_on = 1'b0;
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
